>>> rtl/tlpq_pkg.sv
// Package for the three-level priority queue demote unit.
// Holds sizes, operation and status codes and the sequencer state type.
// No dependencies.
`default_nettype none
package tlpq_pkg;
  localparam int unsigned EntryCount = 256;
  localparam int unsigned LevelCount = 3;
  localparam int unsigned IdW = 8;
  localparam int unsigned LvlW = 2;

  typedef logic [IdW-1:0] id_t;
  typedef logic [LvlW-1:0] lvl_t;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_POP    = 2'd2,
    FUNC_DEMOTE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEVEL = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LINKS,
    S_UNLINK,
    S_PUSH,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

>>> rtl/three_level_priority_queue_demote_unit.sv
// Top level of the three-level priority queue demote unit.
// Depends on tlpq_pkg for sizes, codes and the sequencer state type.
// Holds the link memories, level pointers and the operation sequencer.
`default_nettype none
// Every transaction takes the same fixed walk through five sequencer states.
// The walk is S_READ (checks and the level read), S_LINKS (the link read),
// S_UNLINK, S_PUSH and S_DONE. The result strobe done_o is high in S_DONE.
// busy_o stays high from the accepting edge through the strobe cycle. The
// next start is taken in the cycle after the strobe at the earliest. The entry
// memories are read at one address per cycle with registered data, and each
// has a single write port. The strobe is high for a single cycle and the
// receiver cannot stall it; status_o, out_id_o and out_level_o are registered
// and hold until the next start is taken. Presence bits reset to zero, so no
// clearing pass is needed.
module three_level_priority_queue_demote_unit
  import tlpq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] entry_id_i,
  input  wire logic [2:0] entry_level_i,
  output logic            done_o,
  output logic [2:0]      status_o,
  output logic [7:0]      out_id_o,
  output logic [1:0]      out_level_o
);
  // Presence bits reset to zero; the other stores are undefined until written.
  logic [EntryCount-1:0] present_q;
  lvl_t level_mem [EntryCount];
  id_t  next_mem  [EntryCount];
  id_t  prev_mem  [EntryCount];
  id_t  head_q [LevelCount];
  id_t  tail_q [LevelCount];
  logic [LevelCount-1:0] nonempty_q;

  state_e state_q, state_d;
  func_e  func_q;
  id_t    id_q;
  logic [2:0] lvl_in_q;
  status_e status_q;
  id_t     oid_q;
  lvl_t    olvl_q;
  lvl_t    cur_lvl_q;   // 1-based level of the entry being unlinked
  id_t     nxt_q, prv_q;
  logic    do_unlink_q, do_push_q, push_tail_q;
  lvl_t    push_lvl_q;  // 1-based target level

  // Registered memory read data.
  lvl_t rd_level_q;

  // Pick the highest non-empty level.
  lvl_t top_lvl;
  always_comb begin
    top_lvl = '0;
    for (int l = 0; l < LevelCount; l++) begin
      if (nonempty_q[l]) top_lvl = lvl_t'(l + 1);
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (start_i) state_d = S_READ;
      S_READ:   state_d = S_LINKS;
      S_LINKS:  state_d = S_UNLINK;
      S_UNLINK: state_d = S_PUSH;
      S_PUSH:   state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Output logic.
  always_comb begin
    busy_o      = (state_q != S_IDLE);
    done_o      = (state_q == S_DONE);
    status_o    = status_q;
    out_id_o    = oid_q;
    out_level_o = olvl_q;
  end

  // Entry memory reads: one address per cycle, data registered.
  id_t rd_addr;
  assign rd_addr = id_q;
  always_ff @(posedge clk_i) begin
    rd_level_q <= level_mem[rd_addr];
    nxt_q      <= next_mem[rd_addr];
    prv_q      <= prev_mem[rd_addr];
  end

  // Link memory writes from the unlink and push steps.
  logic wr_nxt_en, wr_prv_en, wr_lvl_en;
  id_t  wr_nxt_a, wr_nxt_d, wr_prv_a, wr_prv_d;
  lvl_t wr_lvl_d;
  logic [1:0] ul;   // 0-based level indexes
  logic [1:0] pl;
  assign ul = cur_lvl_q - 2'd1;
  assign pl = push_lvl_q - 2'd1;

  always_comb begin
    wr_nxt_en = 1'b0; wr_prv_en = 1'b0; wr_lvl_en = 1'b0;
    wr_nxt_a = prv_q; wr_nxt_d = nxt_q;
    wr_prv_a = nxt_q; wr_prv_d = prv_q;
    wr_lvl_d = push_lvl_q;
    if (state_q == S_UNLINK && do_unlink_q &&
        head_q[ul] != id_q && tail_q[ul] != id_q) begin
      wr_nxt_en = 1'b1;
      wr_prv_en = 1'b1;
    end
    if (state_q == S_PUSH && do_push_q) begin
      wr_lvl_en = 1'b1;
      // A demote out of level 1 only records level 0 and touches no list.
      if (push_lvl_q != '0 && nonempty_q[pl]) begin
        wr_nxt_en = 1'b1;
        wr_prv_en = 1'b1;
        if (push_tail_q) begin
          wr_nxt_a = tail_q[pl]; wr_nxt_d = id_q;
          wr_prv_a = id_q;       wr_prv_d = tail_q[pl];
        end else begin
          wr_prv_a = head_q[pl]; wr_prv_d = id_q;
          wr_nxt_a = id_q;       wr_nxt_d = head_q[pl];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_nxt_en) next_mem[wr_nxt_a] <= wr_nxt_d;
    if (wr_prv_en) prev_mem[wr_prv_a] <= wr_prv_d;
    if (wr_lvl_en) level_mem[id_q] <= wr_lvl_d;
  end

  // Sequencer datapath: decode, unlink and push of pointers and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      nonempty_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            func_q   <= func_e'(func_i);
            id_q     <= entry_id_i;
            lvl_in_q <= entry_level_i;
            status_q <= ST_OK;
            oid_q    <= '0;
            olvl_q   <= '0;
            do_unlink_q <= 1'b0;
            do_push_q   <= 1'b0;
          end
        end
        S_READ: begin
          // Decode; pop targets the head of the top level.
          unique case (func_q)
            FUNC_INSERT: begin
              if (lvl_in_q < 3'd1 || lvl_in_q > 3'(LevelCount)) status_q <= ST_BAD_LEVEL;
              else if (present_q[id_q]) status_q <= ST_DUPLICATE;
              else begin
                do_push_q   <= 1'b1;
                push_tail_q <= 1'b1;
                push_lvl_q  <= lvl_t'(lvl_in_q);
              end
            end
            FUNC_QUERY: if (!present_q[id_q]) status_q <= ST_ABSENT;
            FUNC_POP: begin
              if (top_lvl == '0) status_q <= ST_EMPTY;
              else begin
                id_q        <= head_q[top_lvl - 2'd1];
                oid_q       <= head_q[top_lvl - 2'd1];
                cur_lvl_q   <= top_lvl;
                do_unlink_q <= 1'b1;
              end
            end
            FUNC_DEMOTE: if (!present_q[id_q]) status_q <= ST_ABSENT;
            default: ;
          endcase
        end
        S_LINKS: begin
          // Level read data is valid now for query and demote.
          if (status_q == ST_OK) begin
            if (func_q == FUNC_QUERY) olvl_q <= rd_level_q;
            if (func_q == FUNC_DEMOTE) begin
              cur_lvl_q   <= rd_level_q;
              do_unlink_q <= (rd_level_q != '0);
              if (rd_level_q > 2'd1) begin
                do_push_q   <= 1'b1;
                push_tail_q <= 1'b0;
                push_lvl_q  <= rd_level_q - 2'd1;
              end else begin
                present_q[id_q] <= 1'b0;
                if (rd_level_q == 2'd1) begin
                  do_push_q  <= 1'b1;  // only records level 0
                  push_lvl_q <= '0;
                end
              end
            end
            if (func_q == FUNC_POP) present_q[id_q] <= 1'b0;
          end
        end
        S_UNLINK: begin
          if (do_unlink_q) begin
            if (head_q[ul] == id_q && tail_q[ul] == id_q) nonempty_q[ul] <= 1'b0;
            else if (head_q[ul] == id_q) head_q[ul] <= nxt_q;
            else if (tail_q[ul] == id_q) tail_q[ul] <= prv_q;
          end
        end
        S_PUSH: begin
          if (do_push_q && push_lvl_q != '0) begin
            if (func_q == FUNC_INSERT) present_q[id_q] <= 1'b1;
            if (nonempty_q[pl]) begin
              if (push_tail_q) tail_q[pl] <= id_q;
              else head_q[pl] <= id_q;
            end else begin
              head_q[pl] <= id_q;
              tail_q[pl] <= id_q;
              nonempty_q[pl] <= 1'b1;
            end
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> verif/tb.sv
// Testbench for the three-level priority queue demote unit.
// Depends on tlpq_pkg and three_level_priority_queue_demote_unit; a scoreboard class
// predicts each transaction's status, popped ID and queried level.
`timescale 1ns / 100ps
module tb;
  import tlpq_pkg::*;

  // Scoreboard: holds a shadow of the queue and the expected results in order.
  class queue_scoreboard;
    bit           in_queue [EntryCount];
    lvl_t         entry_lvl [EntryCount];
    id_t          fifo [LevelCount][$];
    status_e      want_status [$];
    id_t          want_id [$];
    lvl_t         want_lvl [$];
    int           errors;

    // Works out the result of one accepted transaction and updates the shadow.
    function void note_input(func_e f, id_t id, logic [2:0] lv);
      status_e st;
      id_t     oid;
      lvl_t    olv;
      int      l;
      st = ST_OK;
      oid = '0;
      olv = '0;
      case (f)
        FUNC_INSERT: begin
          if (lv < 1 || lv > LevelCount) st = ST_BAD_LEVEL;
          else if (in_queue[id]) st = ST_DUPLICATE;
          else begin
            in_queue[id] = 1'b1;
            entry_lvl[id] = lv[1:0];
            fifo[lv - 1].insert(fifo[lv - 1].size(), id);
          end
        end
        FUNC_QUERY: begin
          if (!in_queue[id]) st = ST_ABSENT;
          else olv = entry_lvl[id];
        end
        FUNC_POP: begin
          l = LevelCount - 1;
          while (l >= 0 && fifo[l].size() == 0) l--;
          if (l < 0) st = ST_EMPTY;
          else begin
            oid = fifo[l][0];
            fifo[l].delete(0);
            in_queue[oid] = 1'b0;
          end
        end
        default: begin
          if (!in_queue[id]) st = ST_ABSENT;
          else begin
            l = entry_lvl[id] - 1;
            for (int k = 0; k < fifo[l].size(); k++) begin
              if (fifo[l][k] == id) begin
                fifo[l].delete(k);
                break;
              end
            end
            entry_lvl[id] = entry_lvl[id] - 2'd1;
            if (entry_lvl[id] == 0) in_queue[id] = 1'b0;
            else fifo[l - 1].insert(0, id);
          end
        end
      endcase
      want_status.insert(want_status.size(), st);
      want_id.insert(want_id.size(), oid);
      want_lvl.insert(want_lvl.size(), olv);
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(logic [2:0] st, id_t oid, lvl_t olv);
      if (want_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%0d level=%0d", $time, st, oid, olv);
        errors++;
        return;
      end
      if (st !== want_status[0]) begin
        $display("%0t: status expected %0d actual %0d", $time, want_status[0], st);
        errors++;
      end
      if (oid !== want_id[0]) begin
        $display("%0t: out_id expected %0d actual %0d", $time, want_id[0], oid);
        errors++;
      end
      if (olv !== want_lvl[0]) begin
        $display("%0t: out_level expected %0d actual %0d", $time, want_lvl[0], olv);
        errors++;
      end
      want_status.delete(0);
      want_id.delete(0);
      want_lvl.delete(0);
    endfunction

    function int pending();
      return want_status.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] func;
  logic [7:0] entry_id;
  logic [2:0] entry_level;
  logic       done;
  logic [2:0] status;
  logic [7:0] out_id;
  logic [1:0] out_level;

  queue_scoreboard sb;
  int idle_cycles;
  bit stim_done;
  bit small_ids;

  three_level_priority_queue_demote_unit DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .func_i(func), .entry_id_i(entry_id), .entry_level_i(entry_level),
    .done_o(done), .status_o(status), .out_id_o(out_id), .out_level_o(out_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note accepted transactions and check results at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (done) sb.check_result(status, out_id, out_level);
      if (start && !busy) sb.note_input(func_e'(func), entry_id, entry_level);
    end
  end

  // Watchdog: counts cycles without an accepted transaction or result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one transaction after a random gap (none while small_ids is set) and waits for it to be taken.
  task automatic send(func_e f, logic [7:0] id, logic [2:0] lv);
    int gap;
    gap = (small_ids) ? 0 : $urandom_range(0, 11);
    repeat (gap) @(negedge clk);
    func <= f;
    entry_id <= id;
    entry_level <= lv;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Random content drawn mostly from a small pool of IDs so entries recur.
  task automatic send_random();
    int pick;
    logic [7:0] id;
    logic [2:0] lv;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
    lv = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 3));
    if (pick < 40) send(FUNC_INSERT, id, lv);
    else if (pick < 55) send(FUNC_QUERY, id, 3'($urandom));
    else if (pick < 75) send(FUNC_POP, 8'($urandom), 3'($urandom));
    else send(FUNC_DEMOTE, id, 3'($urandom));
  endtask

  initial begin
    sb = new();
    start = 1'b0;
    func = '0;
    entry_id = '0;
    entry_level = '0;
    rst_n = 1'b0;
    idle_cycles = 0;
    small_ids = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pop, bad levels, extremes, duplicate, demote paths.
    send(FUNC_POP, 8'd0, 3'd0);
    send(FUNC_QUERY, 8'd255, 3'd7);
    send(FUNC_DEMOTE, 8'd0, 3'd0);
    send(FUNC_INSERT, 8'd1, 3'd0);
    send(FUNC_INSERT, 8'd1, 3'd4);
    send(FUNC_INSERT, 8'd1, 3'd7);
    send(FUNC_INSERT, 8'd0, 3'd1);
    send(FUNC_INSERT, 8'd255, 3'd3);
    send(FUNC_INSERT, 8'd0, 3'd2);
    send(FUNC_INSERT, 8'd0, 3'd5);
    send(FUNC_INSERT, 8'd170, 3'd3);
    send(FUNC_INSERT, 8'd85, 3'd2);
    send(FUNC_INSERT, 8'd7, 3'd3);
    send(FUNC_QUERY, 8'd255, 3'd0);
    send(FUNC_DEMOTE, 8'd170, 3'd0);
    send(FUNC_DEMOTE, 8'd7, 3'd0);
    send(FUNC_DEMOTE, 8'd0, 3'd0);
    send(FUNC_QUERY, 8'd0, 3'd0);
    send(FUNC_POP, 8'd255, 3'd7);
    send(FUNC_POP, 8'd0, 3'd0);
    send(FUNC_POP, 8'd0, 3'd0);
    send(FUNC_POP, 8'd0, 3'd0);
    send(FUNC_POP, 8'd0, 3'd0);
    send(FUNC_POP, 8'd0, 3'd0);

    // Random: a back-to-back stretch, then runs with random gaps.
    small_ids = 1'b1;
    repeat (150) send_random();
    small_ids = 1'b0;
    repeat (1100) send_random();

    // Drain: wait for outstanding results, then report the error count.
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
